FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasteriser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_AT(label, clk, rst_n, !(expr))

`endif

FILE: sv/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasteriser package
// Widths, request codes, octant codes and beat types shared by the rasteriser.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int STEP_WIDTH  = COORD_WIDTH + 2;
    localparam int ERR_WIDTH   = COORD_WIDTH + 4;
    localparam int COLOR_WIDTH = 24;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        OCT_X_RISE = 2'd0,
        OCT_X_FALL = 2'd1,
        OCT_Y_RISE = 2'd2,
        OCT_Y_FALL = 2'd3
    } octant_t;

    typedef struct packed {
        logic                          req_type;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic        [COLOR_WIDTH-1:0] pen_color;
    } req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
        logic        [COLOR_WIDTH-1:0] pixel_color;
        logic                          last_pixel;
    } pix_t;

    typedef struct packed {
        logic                          busy;
        octant_t                       octant;
        logic signed [COORD_WIDTH-1:0] cur_x;
        logic signed [COORD_WIDTH-1:0] cur_y;
        logic signed [COORD_WIDTH-1:0] stop_coord;
        logic signed [STEP_WIDTH-1:0]  step_a;
        logic signed [STEP_WIDTH-1:0]  step_b;
        logic signed [ERR_WIDTH-1:0]   error_term;
        logic        [COLOR_WIDTH-1:0] line_color;
    } line_t;

endpackage

FILE: sv/lr_setup.sv
// ----------------------------------------------------------------------------
// Line setup
// Orders the endpoints, picks the octant rule and loads the decision term.
// ----------------------------------------------------------------------------
module lr_setup
    import lr_pkg::*;
(
    input  req_t  req,
    output line_t line
);

    logic signed [COORD_WIDTH-1:0] x0;
    logic signed [COORD_WIDTH-1:0] y0;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic signed [COORD_WIDTH:0]   dx;
    logic signed [COORD_WIDTH:0]   ndx;
    logic signed [COORD_WIDTH:0]   dy;
    logic        [COORD_WIDTH:0]   dy_mag;
    logic signed [STEP_WIDTH-1:0]  a;
    logic signed [STEP_WIDTH-1:0]  b;
    logic signed [ERR_WIDTH-1:0]   a_ext;
    logic signed [ERR_WIDTH-1:0]   b_ext;
    logic signed [ERR_WIDTH-1:0]   ndx_ext;
    logic signed [ERR_WIDTH-1:0]   dy_ext;
    logic                          x_major;

    always_comb
    begin
        if (req.end_x < req.start_x)
        begin
            x0 = req.end_x;
            y0 = req.end_y;
            x1 = req.start_x;
            y1 = req.start_y;
        end
        else
        begin
            x0 = req.start_x;
            y0 = req.start_y;
            x1 = req.end_x;
            y1 = req.end_y;
        end
    end

    assign dx  = {x1[COORD_WIDTH-1], x1} - {x0[COORD_WIDTH-1], x0};
    assign ndx = {x0[COORD_WIDTH-1], x0} - {x1[COORD_WIDTH-1], x1};
    assign dy  = {y1[COORD_WIDTH-1], y1} - {y0[COORD_WIDTH-1], y0};

    assign dy_mag  = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : dy;
    assign x_major = (dx >= $signed({1'b0, dy_mag[COORD_WIDTH-1:0]})) && !dy_mag[COORD_WIDTH];

    assign a = {dy, 1'b0};
    assign b = {ndx, 1'b0};

    assign a_ext   = {{(ERR_WIDTH-STEP_WIDTH){a[STEP_WIDTH-1]}}, a};
    assign b_ext   = {{(ERR_WIDTH-STEP_WIDTH){b[STEP_WIDTH-1]}}, b};
    assign ndx_ext = {{(ERR_WIDTH-COORD_WIDTH-1){ndx[COORD_WIDTH]}}, ndx};
    assign dy_ext  = {{(ERR_WIDTH-COORD_WIDTH-1){dy[COORD_WIDTH]}}, dy};

    always_comb
    begin
        line.busy       = 1'b1;
        line.cur_x      = x0;
        line.cur_y      = y0;
        line.step_a     = a;
        line.step_b     = b;
        line.line_color = req.pen_color;
        if (x_major)
        begin
            line.stop_coord = x1;
            if (!dy[COORD_WIDTH])
            begin
                line.octant     = OCT_X_RISE;
                line.error_term = a_ext + ndx_ext;
            end
            else
            begin
                line.octant     = OCT_X_FALL;
                line.error_term = a_ext - ndx_ext;
            end
        end
        else
        begin
            line.stop_coord = y1;
            if (!dy[COORD_WIDTH])
            begin
                line.octant     = OCT_Y_RISE;
                line.error_term = b_ext + dy_ext;
            end
            else
            begin
                line.octant     = OCT_Y_FALL;
                line.error_term = -b_ext - dy_ext;
            end
        end
    end

endmodule

FILE: sv/lr_stepper.sv
// ----------------------------------------------------------------------------
// Line stepper
// Emits the current pixel and advances the coordinates and decision term.
// ----------------------------------------------------------------------------
module lr_stepper
    import lr_pkg::*;
(
    input  line_t line,
    output line_t line_next,
    output pix_t  pix
);

    logic signed [ERR_WIDTH-1:0] err;
    logic signed [ERR_WIDTH-1:0] a_ext;
    logic signed [ERR_WIDTH-1:0] b_ext;
    logic                        err_pos;
    logic                        err_neg;
    logic                        last;

    assign err     = line.error_term;
    assign a_ext   = {{(ERR_WIDTH-STEP_WIDTH){line.step_a[STEP_WIDTH-1]}}, line.step_a};
    assign b_ext   = {{(ERR_WIDTH-STEP_WIDTH){line.step_b[STEP_WIDTH-1]}}, line.step_b};
    assign err_neg = err[ERR_WIDTH-1];
    assign err_pos = !err[ERR_WIDTH-1] && (err != '0);

    assign last = ((line.octant == OCT_X_RISE) || (line.octant == OCT_X_FALL))
                ? (line.cur_x == line.stop_coord)
                : (line.cur_y == line.stop_coord);

    always_comb
    begin
        pix.pixel_x     = line.cur_x;
        pix.pixel_y     = line.cur_y;
        pix.pixel_color = line.line_color;
        pix.last_pixel  = last;
    end

    always_comb
    begin
        line_next      = line;
        line_next.busy = !last;
        case (line.octant)
            OCT_X_RISE:
            begin
                line_next.cur_x      = line.cur_x + COORD_WIDTH'(1);
                line_next.cur_y      = line.cur_y + COORD_WIDTH'(err_pos);
                line_next.error_term = err + a_ext + (err_pos ? b_ext : '0);
            end
            OCT_X_FALL:
            begin
                line_next.cur_x      = line.cur_x + COORD_WIDTH'(1);
                line_next.cur_y      = line.cur_y - COORD_WIDTH'(err_neg);
                line_next.error_term = err + a_ext - (err_neg ? b_ext : '0);
            end
            OCT_Y_RISE:
            begin
                line_next.cur_x      = line.cur_x + COORD_WIDTH'(err_neg);
                line_next.cur_y      = line.cur_y + COORD_WIDTH'(1);
                line_next.error_term = err + b_ext + (err_neg ? a_ext : '0);
            end
            default:
            begin
                line_next.cur_x      = line.cur_x + COORD_WIDTH'(err_pos);
                line_next.cur_y      = line.cur_y - COORD_WIDTH'(1);
                line_next.error_term = err - b_ext + (err_pos ? a_ext : '0);
            end
        endcase
    end

endmodule

FILE: sv/line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasteriser
// Midpoint line rasteriser producing one pixel beat per step request on an active line.
// ----------------------------------------------------------------------------
// A start beat latches two endpoints and a colour and produces no pixel; each
// step beat while a line is active produces one pixel beat, the final one with
// last_pixel set, after which step beats produce nothing until the next start.
// A start beat abandons any line in progress. One request beat is taken every
// clock while the pixel side keeps up; a step beat goes from the request
// register through the single setup or stepper stage into the pixel register, and
// a stalled pixel beat holds the request register and then the request channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_rasterizer
    import lr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic  req_valid_reg;
    req_t  req_reg;
    line_t line_reg;
    line_t line_next;
    line_t setup_line;
    line_t step_line;
    pix_t  step_pix;
    logic  pix_valid_reg;
    logic  pix_valid_next;
    pix_t  pix_reg;
    logic  advance;
    logic  req_fire;
    logic  work;
    logic  is_step;
    logic  emit;

    lr_setup u_setup (
        .req  (req_reg),
        .line (setup_line)
    );

    lr_stepper u_stepper (
        .line      (line_reg),
        .line_next (step_line),
        .pix       (step_pix)
    );

    assign advance   = !pix_valid_reg || pix_ready;
    assign req_ready = !req_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;
    assign work      = req_valid_reg && advance;
    assign is_step   = (req_reg.req_type == REQ_STEP);
    assign emit      = work && is_step && line_reg.busy;

    always_comb
    begin
        line_next = line_reg;
        if (work)
        begin
            if (!is_step)
            begin
                line_next = setup_line;
            end
            else if (line_reg.busy)
            begin
                line_next = step_line;
            end
        end
    end

    assign pix_valid_next = emit || (pix_valid_reg && !pix_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
            line_reg      <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end
            pix_valid_reg <= pix_valid_next;
            line_reg      <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (emit)
        begin
            pix_reg <= step_pix;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    `ASSERT_NEVER(a_hold_ready, clk, rst_n, req_valid_reg && !advance && req_ready)
    `ASSERT_AT(a_start_busy, clk, rst_n, (work && !is_step) |=> line_reg.busy)
    `ASSERT_AT(a_last_idle, clk, rst_n, (emit && step_pix.last_pixel) |=> !line_reg.busy)
    `ASSERT_AT(a_idle_quiet, clk, rst_n, (work && !emit && pix_ready) |=> !pix_valid)

endmodule

FILE: sim/tb_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Drives start and step beats through the request channel and checks every
// pixel beat against an in-bench midpoint line predictor. A short directed
// table covers degenerate lines, coordinate extremes, endpoint swapping, every
// octant and abandoned lines. Random line sequences with random stalls on
// both channels follow.
// ----------------------------------------------------------------------------
module tb_line_rasterizer;

    import lr_pkg::*;

    typedef struct {
        req_t beat;
        bit   fixed;
        bit   has_pix;
        pix_t pix;
    } row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    pix_t pix;

    line_t trace = '0;
    pix_t  pending_pixels[$];
    int    errors = 0;
    int    worked = 0;
    bit    brisk = 1'b0;
    bit    long_hold = 1'b0;

    always #1 clk = ~clk;

    line_rasterizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    function automatic bit raster_advance(input req_t r, output pix_t p);
        longint x0, y0, x1, y1, t, a, b, err;
        bit     fin;
        p = '0;
        if (r.req_type == REQ_START)
        begin
            x0 = $signed(r.start_x);
            y0 = $signed(r.start_y);
            x1 = $signed(r.end_x);
            y1 = $signed(r.end_y);
            if (x1 < x0)
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            a = 2 * (y1 - y0);
            b = 2 * (x0 - x1);
            if ((b < 0 ? -b : b) >= (a < 0 ? -a : a))
            begin
                trace.octant     = (a >= 0) ? OCT_X_RISE : OCT_X_FALL;
                err              = (a >= 0) ? a + b / 2 : a - b / 2;
                trace.stop_coord = COORD_WIDTH'(x1);
            end
            else
            begin
                trace.octant     = (a >= 0) ? OCT_Y_RISE : OCT_Y_FALL;
                err              = (a >= 0) ? b + a / 2 : -b - a / 2;
                trace.stop_coord = COORD_WIDTH'(y1);
            end
            trace.step_a     = STEP_WIDTH'(a);
            trace.step_b     = STEP_WIDTH'(b);
            trace.error_term = ERR_WIDTH'(err);
            trace.cur_x      = COORD_WIDTH'(x0);
            trace.cur_y      = COORD_WIDTH'(y0);
            trace.line_color = r.pen_color;
            trace.busy       = 1'b1;
            return 1'b0;
        end
        if (!trace.busy)
            return 1'b0;

        if (trace.octant == OCT_X_RISE || trace.octant == OCT_X_FALL)
            fin = (trace.cur_x == trace.stop_coord);
        else
            fin = (trace.cur_y == trace.stop_coord);
        p.pixel_x     = trace.cur_x;
        p.pixel_y     = trace.cur_y;
        p.pixel_color = trace.line_color;
        p.last_pixel  = fin;

        err = $signed(trace.error_term);
        a   = $signed(trace.step_a);
        b   = $signed(trace.step_b);
        x0  = $signed(trace.cur_x);
        y0  = $signed(trace.cur_y);
        case (trace.octant)
            OCT_X_RISE:
            begin
                if (err > 0)
                begin
                    y0 = y0 + 1;
                    err = err + b;
                end
                x0 = x0 + 1;
                err = err + a;
            end
            OCT_X_FALL:
            begin
                if (err < 0)
                begin
                    y0 = y0 - 1;
                    err = err - b;
                end
                x0 = x0 + 1;
                err = err + a;
            end
            OCT_Y_RISE:
            begin
                if (err < 0)
                begin
                    x0 = x0 + 1;
                    err = err + a;
                end
                y0 = y0 + 1;
                err = err + b;
            end
            default:
            begin
                if (err > 0)
                begin
                    x0 = x0 + 1;
                    err = err + a;
                end
                y0 = y0 - 1;
                err = err - b;
            end
        endcase
        trace.cur_x      = COORD_WIDTH'(x0);
        trace.cur_y      = COORD_WIDTH'(y0);
        trace.error_term = ERR_WIDTH'(err);
        if (fin)
            trace.busy = 1'b0;
        return 1'b1;
    endfunction

    function automatic row_t go(int sx, int sy, int ex, int ey, int c);
        row_t w;
        w.beat.req_type  = REQ_START;
        w.beat.start_x   = COORD_WIDTH'(sx);
        w.beat.start_y   = COORD_WIDTH'(sy);
        w.beat.end_x     = COORD_WIDTH'(ex);
        w.beat.end_y     = COORD_WIDTH'(ey);
        w.beat.pen_color = COLOR_WIDTH'(c);
        w.fixed   = 1'b1;
        w.has_pix = 1'b0;
        w.pix     = '0;
        return w;
    endfunction

    function automatic row_t tick();
        row_t w;
        w.beat.req_type  = REQ_STEP;
        w.beat.start_x   = COORD_WIDTH'($urandom);
        w.beat.start_y   = COORD_WIDTH'($urandom);
        w.beat.end_x     = COORD_WIDTH'($urandom);
        w.beat.end_y     = COORD_WIDTH'($urandom);
        w.beat.pen_color = COLOR_WIDTH'($urandom);
        w.fixed   = 1'b0;
        w.has_pix = 1'b0;
        w.pix     = '0;
        return w;
    endfunction

    function automatic row_t tick_none();
        row_t w;
        w = tick();
        w.fixed = 1'b1;
        return w;
    endfunction

    function automatic row_t tick_is(int x, int y, int c, bit l);
        row_t w;
        w = tick();
        w.fixed           = 1'b1;
        w.has_pix         = 1'b1;
        w.pix.pixel_x     = COORD_WIDTH'(x);
        w.pix.pixel_y     = COORD_WIDTH'(y);
        w.pix.pixel_color = COLOR_WIDTH'(c);
        w.pix.last_pixel  = l;
        return w;
    endfunction

    task automatic offer(input row_t row);
        int   gap;
        bit   has;
        pix_t want;
        gap = brisk ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= row.beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (row.beat.req_type == REQ_START || trace.busy)
            worked++;
        has = raster_advance(row.beat, want);
        if (row.fixed)
        begin
            has  = row.has_pix;
            want = row.pix;
        end
        if (has)
            pending_pixels.push_back(want);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel beat with none expected, got x %0d y %0d", $time,
                         pix.pixel_x, pix.pixel_y);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix.pixel_x !== want.pixel_x)
                begin
                    errors++;
                    $display("%0t: pixel_x expected %0d, got %0d", $time,
                             want.pixel_x, pix.pixel_x);
                end
                if (pix.pixel_y !== want.pixel_y)
                begin
                    errors++;
                    $display("%0t: pixel_y expected %0d, got %0d", $time,
                             want.pixel_y, pix.pixel_y);
                end
                if (pix.pixel_color !== want.pixel_color)
                begin
                    errors++;
                    $display("%0t: pixel_color expected %h, got %h", $time,
                             want.pixel_color, pix.pixel_color);
                end
                if (pix.last_pixel !== want.last_pixel)
                begin
                    errors++;
                    $display("%0t: last_pixel expected %b, got %b", $time,
                             want.last_pixel, pix.last_pixel);
                end
            end
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = brisk ? 0 : $urandom_range(0, 16);
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall = 300;
            end
            if (stall > 0)
            begin
                pix_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_ready <= 1'b1;
            do @(posedge clk); while (!pix_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        row_t plan[$];
        int   seq, span, ox, oy, steps;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        plan = {
            tick_none(),
            go(0, 0, 0, 0, 24'hFFFFFF),
            tick_is(0, 0, 24'hFFFFFF, 1'b1),
            tick_none(),
            go(-32768, -32768, 32767, 32767, 24'h000000),
            tick_is(-32768, -32768, 24'h000000, 1'b0),
            tick(),
            go(32767, -32768, -32768, 32767, 24'hA5A5A5),
            tick_is(-32768, 32767, 24'hA5A5A5, 1'b0),
            tick(),
            go(3, 1, 0, 0, 24'h5A5A5A),
            tick_is(0, 0, 24'h5A5A5A, 1'b0),
            tick(),
            tick(),
            tick_is(3, 1, 24'h5A5A5A, 1'b1),
            tick_none(),
            go(0, 0, 1, -3, 24'h123456),
            tick_is(0, 0, 24'h123456, 1'b0),
            tick(),
            tick(),
            tick(),
            go(-2, 0, -1, 3, 24'h0F0F0F),
            tick_is(-2, 0, 24'h0F0F0F, 1'b0),
            tick(),
            go(0, 0, 3, -1, 24'hF0F0F0),
            tick()
        };
        foreach (plan[i])
            offer(plan[i]);

        seq = 0;
        while (worked < 1650)
        begin
            brisk = ($urandom_range(0, 3) == 0);
            if (seq == 20)
            begin
                long_hold = 1'b1;
                brisk = 1'b1;
            end
            if (seq == 40 && pending_pixels.size() != 0)
            begin
                req_valid <= 1'b0;
                while (pending_pixels.size() != 0)
                    @(negedge clk);
            end
            if (seq != 20 && $urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    plan[0] = tick();
                    plan[0].beat.req_type = 1'($urandom);
                    offer(plan[0]);
                end
            end
            else
            begin
                span = (seq == 20 || $urandom_range(0, 7) == 0) ? 2000 : 12;
                ox = $signed(COORD_WIDTH'($urandom));
                oy = $signed(COORD_WIDTH'($urandom));
                offer(go(ox, oy,
                         ox + $urandom_range(0, 2 * span) - span,
                         oy + $urandom_range(0, 2 * span) - span,
                         $urandom));
                steps = 0;
                while (trace.busy && steps < 48)
                begin
                    offer(tick());
                    steps++;
                end
                repeat ($urandom_range(0, 2))
                    offer(tick());
            end
            seq++;
        end

        req_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
